// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helper macros for the cuckoo hash table design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CHT_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CHT_ASSERT(label, clk, rst, prop, msg)
`define CHT_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// File: design/cht_pkg.sv
// ----------------------------------------------------------------------------
// cht_pkg
// Shared types and constants for the cuckoo hash table.
// ----------------------------------------------------------------------------
`default_nettype none
package cht_pkg;
  localparam int Slots   = 1024;
  localparam int IdxW    = $clog2(Slots);
  localparam int KeyW    = 31;
  localparam int SizeW   = 11;
  localparam int LoopW   = 8;
  localparam int CntW    = $clog2(Slots + 1);

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_LOOKUP = 2'd2;
  localparam logic [1:0] ACT_SPARE  = 2'd3;   // unused code, acts as lookup

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_PRESENT  = 3'd1;
  localparam logic [2:0] ST_REMOVED  = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_FOUND    = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;

  localparam logic [1:0] TID_NONE   = 2'd0;
  localparam logic [1:0] TID_FIRST  = 2'd1;
  localparam logic [1:0] TID_SECOND = 2'd2;

  localparam logic [0:0] CFG_TABLE_SIZE = 1'd0;
  localparam logic [0:0] CFG_MAX_LOOP   = 1'd1;

  // datapath commands
  typedef struct packed {
    logic load_in;      // capture input key, start hashing it
    logic hash_carry;   // start hashing the carried key
    logic rd1;          // read table one at hash one
    logic rd2;          // read table two at hash two
    logic probe_wr1;    // clear table one entry at hash one (remove)
    logic probe_wr2;
    logic ins_wr1;      // write carry into table one, take old occupant
    logic ins_wr2;      // write carry into table two, take old occupant
  } cmd_t;

  typedef struct packed {
    logic hash_done;
    logic hit1;
    logic hit2;
    logic old_valid;
    logic clearing;     // tables being emptied after reset
  } stat_t;
endpackage
`default_nettype wire

// File: design/cuckoo_hash_table_core.sv
// ----------------------------------------------------------------------------
// cuckoo_hash_table_core
// Two-table cuckoo hash set: insert, remove and lookup of 31-bit keys.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries action and key; the output
// channel (out_valid/out_stall) returns one result beat per item.
// One item is in work at a time; the next is taken the cycle after its
// result beat leaves. Each key hash goes through a bit-serial remainder
// unit that flags completion. Lookup, remove, already-present and
// zero-round inserts answer after one hash and a read of both tables.
// Other inserts make at least one table move; each further move (half an
// eviction round) first hashes the carried key, up to 2*max_loop moves in
// all. The remainder unit sets the pace.
// in_stall is high while an item is in work, a result beat waits, or the
// tables are being cleared. A stalled result holds its payload until taken.
// Reset restores table_size 1024 and max_loop 16 and starts a clearing pass
// that empties every slot of both tables after rst falls.
// Configuration writes go straight in through cfg_we/cfg_index/cfg_data.
// ----------------------------------------------------------------------------
`default_nettype none
module cuckoo_hash_table_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [10:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  action,
  input  wire logic [30:0] key,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       status,
  output logic [1:0]       table_id,
  output logic [9:0]       slot,
  output logic [30:0]      homeless_key
);
  logic [cht_pkg::SizeW-1:0] table_size;
  logic [cht_pkg::LoopW-1:0] max_loop;
  cht_pkg::cmd_t  cmd;
  cht_pkg::stat_t stat;
  logic [cht_pkg::KeyW-1:0] carry;
  logic [cht_pkg::IdxW-1:0] h1, h2, first_h1;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= cht_pkg::SizeW'(1024);
      max_loop <= cht_pkg::LoopW'(16);
    end else if (cfg_we) begin
      unique case (cfg_index)
        cht_pkg::CFG_TABLE_SIZE: table_size <= cfg_data;
        cht_pkg::CFG_MAX_LOOP:   max_loop <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  cht_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .in_key(key),
    .table_size(table_size), .carry(carry), .h1(h1), .h2(h2), .first_h1(first_h1)
  );

  cht_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .max_loop(max_loop), .cmd(cmd), .stat(stat),
    .carry(carry), .h1(h1), .h2(h2), .first_h1(first_h1),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .table_id(table_id), .slot(slot), .homeless_key(homeless_key)
  );
endmodule
`default_nettype wire

// File: design/cht_mod.sv
// ----------------------------------------------------------------------------
// cht_mod
// Iterative remainder unit: computes x mod m1 and x mod m2, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module cht_mod (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [cht_pkg::KeyW-1:0] x,
  input  wire logic [cht_pkg::CntW-1:0] m1,
  input  wire logic [cht_pkg::CntW-1:0] m2,
  output logic                          done,
  output logic [cht_pkg::IdxW-1:0]      r1,
  output logic [cht_pkg::IdxW-1:0]      r2
);
  logic [cht_pkg::KeyW-1:0] sh;
  logic [cht_pkg::CntW-1:0] a1, a2;
  logic [4:0] cnt;
  logic       busy;
  logic [cht_pkg::CntW:0] t1, t2;

  // remainder stays below m, so shifting in one bit stays below 2m
  assign t1 = {a1, sh[cht_pkg::KeyW-1]};
  assign t2 = {a2, sh[cht_pkg::KeyW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(cht_pkg::KeyW - 1);
        sh   <= x;
        a1   <= '0;
        a2   <= '0;
      end else if (busy) begin
        sh <= {sh[cht_pkg::KeyW-2:0], 1'b0};
        a1 <= (t1 >= {1'b0, m1}) ? cht_pkg::CntW'(t1 - {1'b0, m1}) : cht_pkg::CntW'(t1);
        a2 <= (t2 >= {1'b0, m2}) ? cht_pkg::CntW'(t2 - {1'b0, m2}) : cht_pkg::CntW'(t2);
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
    end
  end

  assign r1 = a1[cht_pkg::IdxW-1:0];
  assign r2 = a2[cht_pkg::IdxW-1:0];
endmodule
`default_nettype wire

// File: design/cht_datapath.sv
// ----------------------------------------------------------------------------
// cht_datapath
// Both tables with valid bits, hash unit, carried key and result fields.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module cht_datapath (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire cht_pkg::cmd_t             cmd,
  output cht_pkg::stat_t                 stat,
  input  wire logic [cht_pkg::KeyW-1:0]  in_key,
  input  wire logic [cht_pkg::SizeW-1:0] table_size,
  output logic [cht_pkg::KeyW-1:0]       carry,
  output logic [cht_pkg::IdxW-1:0]       h1,
  output logic [cht_pkg::IdxW-1:0]       h2,
  output logic [cht_pkg::IdxW-1:0]       first_h1
);
  // entry: {valid, key}
  logic [cht_pkg::KeyW:0] mem1 [cht_pkg::Slots];
  logic [cht_pkg::KeyW:0] mem2 [cht_pkg::Slots];
  logic [cht_pkg::KeyW:0] q1, q2;
  logic v1, v2;
  logic [cht_pkg::CntW-1:0] m1, m2;
  logic [cht_pkg::KeyW-1:0] key_r;
  logic hdone;
  logic wr2_last;   // last eviction write went to table two
  logic clearing;
  logic [cht_pkg::IdxW-1:0] clr_idx;
  logic we1, we2;
  logic [cht_pkg::IdxW-1:0] wa1, wa2;
  logic [cht_pkg::KeyW:0] wd1, wd2;
  logic tbl_cmd;

  always_comb begin
    if (table_size < cht_pkg::SizeW'(2)) m1 = cht_pkg::CntW'(2);
    else if (32'(table_size) > cht_pkg::Slots) m1 = cht_pkg::CntW'(cht_pkg::Slots);
    else m1 = cht_pkg::CntW'(table_size);
    m2 = m1 - cht_pkg::CntW'(1);
  end

  cht_mod u_mod (
    .clk(clk), .rst(rst), .start(cmd.load_in | cmd.hash_carry),
    .x(cmd.load_in ? in_key : carry), .m1(m1), .m2(m2),
    .done(hdone), .r1(h1), .r2(h2)
  );

  // one slot of each table emptied per cycle after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx <= '0;
    end else if (clearing) begin
      if (clr_idx == cht_pkg::IdxW'(cht_pkg::Slots - 1)) clearing <= 1'b0;
      clr_idx <= clr_idx + cht_pkg::IdxW'(1);
    end
  end

  always_comb begin
    we1 = clearing | cmd.ins_wr1 | cmd.probe_wr1;
    we2 = clearing | cmd.ins_wr2 | cmd.probe_wr2;
    wa1 = clearing ? clr_idx : h1;
    wa2 = clearing ? clr_idx : h2;
    // remove and clear write an empty entry
    wd1 = cmd.ins_wr1 ? {1'b1, carry} : '0;
    wd2 = cmd.ins_wr2 ? {1'b1, carry} : '0;
  end

  always_ff @(posedge clk) begin
    if (we1) mem1[wa1] <= wd1;
    if (we2) mem2[wa2] <= wd2;
    if (cmd.rd1) q1 <= mem1[h1];
    if (cmd.rd2) q2 <= mem2[h2];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      carry <= in_key;
      key_r <= in_key;
    end
    if (hdone && carry == key_r) first_h1 <= h1;
    if (cmd.ins_wr1) begin
      carry <= q1[cht_pkg::KeyW-1:0];
      wr2_last <= 1'b0;
    end
    if (cmd.ins_wr2) begin
      carry <= q2[cht_pkg::KeyW-1:0];
      wr2_last <= 1'b1;
    end
  end

  assign v1 = q1[cht_pkg::KeyW];
  assign v2 = q2[cht_pkg::KeyW];
  assign tbl_cmd = cmd.ins_wr1 | cmd.ins_wr2 | cmd.probe_wr1 | cmd.probe_wr2;

  assign stat.hash_done = hdone;
  assign stat.hit1 = v1 && q1[cht_pkg::KeyW-1:0] == key_r;
  assign stat.hit2 = v2 && q2[cht_pkg::KeyW-1:0] == key_r;
  // old occupant of whichever table was just written
  assign stat.old_valid = wr2_last ? v2 : v1;
  assign stat.clearing = clearing;

  `CHT_ASSERT(a_one_write, clk, rst, !(cmd.ins_wr1 && cmd.ins_wr2), "two table writes at once")
  `CHT_ASSERT(a_hash_start, clk, rst, !(cmd.load_in && cmd.hash_carry), "double hash start")
  `CHT_ASSERT(a_clr_quiet, clk, rst, clearing |-> !tbl_cmd, "table command during clearing")
endmodule
`default_nettype wire

// File: design/cht_ctrl.sv
// ----------------------------------------------------------------------------
// cht_ctrl
// Sequencer for probe, remove and eviction rounds; holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module cht_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [1:0]                action,
  input  wire logic [cht_pkg::LoopW-1:0] max_loop,
  output cht_pkg::cmd_t                  cmd,
  input  wire cht_pkg::stat_t            stat,
  input  wire logic [cht_pkg::KeyW-1:0]  carry,
  input  wire logic [cht_pkg::IdxW-1:0]  h1,
  input  wire logic [cht_pkg::IdxW-1:0]  h2,
  input  wire logic [cht_pkg::IdxW-1:0]  first_h1,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [2:0]                     status,
  output logic [1:0]                     table_id,
  output logic [9:0]                     slot,
  output logic [cht_pkg::KeyW-1:0]       homeless_key
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_HASH  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_PROBE = 3'd3;
  localparam logic [2:0] S_RD1   = 3'd4;
  localparam logic [2:0] S_WR1   = 3'd5;
  localparam logic [2:0] S_RD2   = 3'd6;
  localparam logic [2:0] S_WR2   = 3'd7;

  logic [2:0] state, state_next;
  logic [1:0] act;
  logic [cht_pkg::LoopW-1:0] rounds;
  logic busy;   // hash of a carried key pending during eviction
  logic half;   // 0: carried key goes to table one, 1: table two
  logic res_ld;
  logic [2:0] res_st;
  logic [1:0] res_tid;
  logic [cht_pkg::IdxW-1:0] res_slot;
  logic [cht_pkg::KeyW-1:0] res_home;
  logic res_full;

  assign in_stall = (state != S_IDLE) || out_valid || stat.clearing;
  assign res_full = res_ld && res_st == cht_pkg::ST_FULL;

  always_comb begin
    cmd = '0;
    state_next = state;
    res_ld = 1'b0;
    res_st = cht_pkg::ST_NOTFOUND;
    res_tid = cht_pkg::TID_NONE;
    res_slot = '0;
    res_home = '0;
    unique case (state)
      S_IDLE: if (in_valid && !in_stall) begin
        cmd.load_in = 1'b1;
        state_next = S_HASH;
      end
      S_HASH: if (stat.hash_done) begin
        cmd.rd1 = 1'b1;
        cmd.rd2 = 1'b1;
        state_next = S_PROBE;
      end
      S_READ: state_next = S_PROBE;
      S_PROBE: begin
        if (act == cht_pkg::ACT_INSERT) begin
          if (stat.hit1 || stat.hit2) begin
            res_ld = 1'b1;
            res_st = cht_pkg::ST_PRESENT;
            res_tid = stat.hit1 ? cht_pkg::TID_FIRST : cht_pkg::TID_SECOND;
            res_slot = stat.hit1 ? h1 : h2;
            state_next = S_IDLE;
          end else if (rounds == '0) begin
            res_ld = 1'b1;
            res_st = cht_pkg::ST_FULL;
            res_home = carry;
            state_next = S_IDLE;
          end else begin
            state_next = S_WR1;
          end
        end else begin
          res_ld = 1'b1;
          if (stat.hit1 || stat.hit2) begin
            res_tid = stat.hit1 ? cht_pkg::TID_FIRST : cht_pkg::TID_SECOND;
            res_slot = stat.hit1 ? h1 : h2;
            if (act == cht_pkg::ACT_REMOVE) begin
              res_st = cht_pkg::ST_REMOVED;
              cmd.probe_wr1 = stat.hit1;
              cmd.probe_wr2 = !stat.hit1;
            end else begin
              res_st = cht_pkg::ST_FOUND;
            end
          end
          state_next = S_IDLE;
        end
      end
      S_RD1: if (stat.hash_done || !busy) begin
        if (half) cmd.rd2 = 1'b1;
        else cmd.rd1 = 1'b1;
        state_next = S_WR1;
      end
      S_WR1: begin
        cmd.ins_wr1 = !half;
        cmd.ins_wr2 = half;
        state_next = S_RD2;
      end
      S_RD2: begin
        // old occupant valid bit was latched with the read
        if (!stat.old_valid) begin
          res_ld = 1'b1;
          res_st = cht_pkg::ST_INSERTED;
          res_tid = cht_pkg::TID_FIRST;
          res_slot = first_h1;
          state_next = S_IDLE;
        end else if (half && rounds == 8'd1) begin
          res_ld = 1'b1;
          res_st = cht_pkg::ST_FULL;
          res_home = carry;
          state_next = S_IDLE;
        end else begin
          cmd.hash_carry = 1'b1;
          state_next = S_WR2;
        end
      end
      S_WR2: state_next = S_RD1;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      half <= 1'b0;
      busy <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (res_ld) out_valid <= 1'b1;
      if (cmd.load_in) begin
        act <= action;
        rounds <= max_loop;
        half <= 1'b0;
        busy <= 1'b0;
      end
      if (cmd.hash_carry) busy <= 1'b1;
      if (state == S_RD1 && (stat.hash_done || !busy)) busy <= 1'b0;
      if (state == S_RD2 && stat.old_valid) begin
        half <= !half;
        if (half) rounds <= rounds - 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_ld) begin
      status <= res_st;
      table_id <= res_tid;
      slot <= 10'(res_slot);
      homeless_key <= res_home;
    end
  end

  `CHT_ASSERT(a_no_accept_busy, clk, rst, cmd.load_in |-> !out_valid, "accept while result pending")
  `CHT_ASSERT(a_res_once, clk, rst, res_ld |-> !out_valid, "result overwritten")
  `CHT_ASSERT(a_full_home, clk, rst, res_full |-> res_tid == cht_pkg::TID_NONE, "full with table")
endmodule
`default_nettype wire
